FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked same-cycle and next-cycle implication checks with active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DCO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dco_pkg.sv
// ----------------------------------------------------------------------------
// dco_pkg
// shared types and constants of the dag canonical order checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dco_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;

  localparam int unsigned ARITY_W   = 2;
  localparam int unsigned CHILD_W   = 10;
  localparam int unsigned LEFT_LSB  = CHILD_W;
  localparam int unsigned NODE_W    = ARITY_W + 2 * CHILD_W;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned COUNT_W   = 11;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_CANON     = 2'd0,
    VERDICT_NONCANON  = 2'd1,
    VERDICT_MALFORMED = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_FETCH,
    WS_LEFT,
    WS_RIGHT,
    WS_SELF
  } walk_state_e;

  typedef struct packed {
    logic done;
    logic canonical;
  } walk_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dco_in_if.sv
// ----------------------------------------------------------------------------
// dco_in_if
// node item channel: valid/ready with one dag node per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dco_in_if;
  logic                             valid;
  logic                             ready;
  logic [dco_pkg::ARITY_W-1:0]      arity;
  logic [dco_pkg::CHILD_W-1:0]      left_child;
  logic [dco_pkg::CHILD_W-1:0]      right_child;
  logic                             last_node;

  modport source (output valid, arity, left_child, right_child, last_node, input ready);
  modport sink   (input valid, arity, left_child, right_child, last_node, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dco_out_if.sv
// ----------------------------------------------------------------------------
// dco_out_if
// result item channel: valid/ready with verdict and node count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dco_out_if;
  logic                           valid;
  logic                           ready;
  logic [dco_pkg::VERDICT_W-1:0]  verdict;
  logic [dco_pkg::COUNT_W-1:0]    node_count;

  modport source (output valid, verdict, node_count, input ready);
  modport sink   (input valid, verdict, node_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dag_canonical_order_checker.sv
// ----------------------------------------------------------------------------
// dag_canonical_order_checker
// loads an expression dag node by node and checks canonical pre-order
// ----------------------------------------------------------------------------
// usage
//   in_i carries one dag node per item (arity, child indices, last flag).
//   node items are taken one per cycle while the block is in its load phase
//   and written into the node store at the running load index.
//   the item marked last_node ends the load; no more items are taken until
//   its result item has been placed in the output register.
//   a malformed dag (child index not below its node, or too many nodes)
//   goes straight to the done state to offer its result, with no walk.
//   otherwise the walk visits nodes from the last one; each visit is a
//   fetch followed, as the node needs, by left, right and self compares
//   on the single shared comparator and the node store read port; a node
//   is fetched at most three times (on entry and after each child).
//   out_o holds verdict and node_count in an output register; while the
//   receiver stalls the block keeps loading the next dag, and a finished
//   walk waits in its done state until the register frees up.
//   reset clears the load count, the sequencers and the output valid; the
//   node store and return stack need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dag_canonical_order_checker #(
  parameter int unsigned MAX_NODES = dco_pkg::MAX_NODES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dco_in_if.sink    in_i,
  dco_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  // compare width wide enough for both child fields and the load index
  localparam int unsigned CMP_W = (CNT_W > dco_pkg::CHILD_W) ? CNT_W : dco_pkg::CHILD_W;

  dco_pkg::top_state_e state_q, state_d;

  logic [CNT_W-1:0] load_count_q, load_count_d;
  logic             malformed_q, malformed_d;
  logic [CNT_W-1:0] n_q, n_d;
  dco_pkg::verdict_e verdict_q, verdict_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [dco_pkg::VERDICT_W-1:0]  out_verdict_q, out_verdict_d;
  logic [dco_pkg::COUNT_W-1:0]    out_count_q, out_count_d;

  logic             accept;
  logic             room;
  logic             bad_now;
  logic             mal_next;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;
  logic             walk_start;

  // node store read side, driven by the walker
  logic                        ns_rd_en;
  logic [IDX_W-1:0]            ns_rd_addr;
  logic [dco_pkg::NODE_W-1:0]  ns_rd_data;
  dco_pkg::walk_stat_t         walk_stat;

  assign in_i.ready = (state_q == dco_pkg::ST_LOAD);
  assign accept     = in_i.valid && in_i.ready;

  // load-side checks for the incoming node
  assign room     = (load_count_q < CNT_W'(MAX_NODES));
  assign bad_now  = !room
                 || ((in_i.arity != '0)
                     && (CMP_W'(in_i.left_child) >= CMP_W'(load_count_q)))
                 || (in_i.arity[1]
                     && (CMP_W'(in_i.right_child) >= CMP_W'(load_count_q)));
  assign mal_next = malformed_q || bad_now;
  assign cnt_next = room ? (load_count_q + CNT_W'(1)) : load_count_q;

  assign walk_start = accept && in_i.last_node && !mal_next;
  assign out_free   = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dco_pkg::ST_LOAD: begin
        if (accept && in_i.last_node) begin
          state_d = mal_next ? dco_pkg::ST_DONE : dco_pkg::ST_WALK;
        end
      end
      dco_pkg::ST_WALK: if (walk_stat.done) state_d = dco_pkg::ST_DONE;
      dco_pkg::ST_DONE: if (out_free) state_d = dco_pkg::ST_LOAD;
      default:          state_d = dco_pkg::ST_LOAD;
    endcase
  end

  // load bookkeeping, verdict and output register
  always_comb begin
    load_count_d  = load_count_q;
    malformed_d   = malformed_q;
    n_d           = n_q;
    verdict_d     = verdict_q;
    out_verdict_d = out_verdict_q;
    out_count_d   = out_count_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    unique case (state_q)
      dco_pkg::ST_LOAD: begin
        if (accept) begin
          if (in_i.last_node) begin
            // the dag is complete: latch its size and start over
            n_d          = cnt_next;
            load_count_d = '0;
            malformed_d  = 1'b0;
            verdict_d    = dco_pkg::VERDICT_MALFORMED;
          end else begin
            load_count_d = cnt_next;
            malformed_d  = mal_next;
          end
        end
      end
      dco_pkg::ST_WALK: begin
        if (walk_stat.done) begin
          verdict_d = walk_stat.canonical ? dco_pkg::VERDICT_CANON
                                          : dco_pkg::VERDICT_NONCANON;
        end
      end
      dco_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          out_count_d   = dco_pkg::COUNT_W'(n_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dco_pkg::ST_LOAD;
      load_count_q <= '0;
      malformed_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      load_count_q <= load_count_d;
      malformed_q  <= malformed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    verdict_q     <= verdict_d;
    out_verdict_q <= out_verdict_d;
    out_count_q   <= out_count_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.verdict    = out_verdict_q;
  assign out_o.node_count = out_count_q;

  // node store: arity, left child, right child packed per entry
  dco_ram #(
    .WIDTH (dco_pkg::NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_store (
    .clk_i   (clk_i),
    .we_i    (accept && room),
    .waddr_i (load_count_q[IDX_W-1:0]),
    .wdata_i ({in_i.arity, in_i.left_child, in_i.right_child}),
    .re_i    (ns_rd_en),
    .raddr_i (ns_rd_addr),
    .rdata_o (ns_rd_data)
  );

  // pre-order walk over the stored dag
  dco_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (walk_start),
    .n_i          (cnt_next),
    .ns_rd_en_o   (ns_rd_en),
    .ns_rd_addr_o (ns_rd_addr),
    .ns_rd_data_i (ns_rd_data),
    .stat_o       (walk_stat)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dco_ram.sv
// ----------------------------------------------------------------------------
// dco_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dco_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dco_walker.sv
// ----------------------------------------------------------------------------
// dco_walker
// pre-order walk sequencer with shared comparator and return stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dco_walker #(
  parameter  int unsigned MAX_NODES = dco_pkg::MAX_NODES_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_NODES),
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CNT_W-1:0]            n_i,
  output      logic                        ns_rd_en_o,
  output      logic [IDX_W-1:0]            ns_rd_addr_o,
  input  wire logic [dco_pkg::NODE_W-1:0]  ns_rd_data_i,
  output      dco_pkg::walk_stat_t         stat_o
);

  dco_pkg::walk_state_e state_q, state_d;
  logic [CNT_W-1:0] top_q, top_d;
  logic [CNT_W-1:0] bottom_q, bottom_d;
  logic [CNT_W-1:0] n_q, n_d;

  logic [dco_pkg::ARITY_W-1:0] arity;
  logic [CNT_W-1:0] left_ix, right_ix;

  // shared comparator
  logic [CNT_W-1:0] cmp_a, cmp_b;
  logic             cmp_lt, cmp_eq;

  // return stack ports
  logic             rs_we, rs_re;
  logic [IDX_W-1:0] rs_waddr;
  logic [CNT_W-1:0] rs_wdata, rs_rdata;

  assign arity    = ns_rd_data_i[dco_pkg::NODE_W-1 -: dco_pkg::ARITY_W];
  assign left_ix  = CNT_W'(ns_rd_data_i[dco_pkg::LEFT_LSB +: dco_pkg::CHILD_W]);
  assign right_ix = CNT_W'(ns_rd_data_i[0 +: dco_pkg::CHILD_W]);

  always_comb begin
    case (state_q)
      dco_pkg::WS_FETCH: begin
        cmp_a = top_q;
        cmp_b = n_q;
      end
      dco_pkg::WS_LEFT: begin
        cmp_a = bottom_q;
        cmp_b = left_ix;
      end
      dco_pkg::WS_RIGHT: begin
        cmp_a = bottom_q;
        cmp_b = right_ix;
      end
      default: begin
        cmp_a = bottom_q;
        cmp_b = top_q;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dco_pkg::WS_IDLE:  if (start_i) state_d = dco_pkg::WS_FETCH;
      dco_pkg::WS_FETCH: state_d = cmp_lt ? dco_pkg::WS_LEFT : dco_pkg::WS_IDLE;
      dco_pkg::WS_LEFT: begin
        if (arity == '0) begin
          state_d = dco_pkg::WS_SELF;
        end else if (cmp_lt) begin
          state_d = dco_pkg::WS_FETCH;
        end else begin
          state_d = dco_pkg::WS_RIGHT;
        end
      end
      dco_pkg::WS_RIGHT: begin
        state_d = (arity[1] && cmp_lt) ? dco_pkg::WS_FETCH : dco_pkg::WS_SELF;
      end
      dco_pkg::WS_SELF:  state_d = cmp_lt ? dco_pkg::WS_IDLE : dco_pkg::WS_FETCH;
      default:           state_d = dco_pkg::WS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    top_d            = top_q;
    bottom_d         = bottom_q;
    n_d              = n_q;
    rs_we            = 1'b0;
    rs_waddr         = top_q[IDX_W-1:0];
    rs_wdata         = top_q;
    rs_re            = 1'b0;
    ns_rd_en_o       = 1'b0;
    stat_o.done      = 1'b0;
    stat_o.canonical = 1'b0;
    unique case (state_q)
      dco_pkg::WS_IDLE: begin
        if (start_i) begin
          top_d    = n_i - CNT_W'(1);
          bottom_d = '0;
          n_d      = n_i;
          rs_we    = 1'b1;
          rs_waddr = IDX_W'(n_i - CNT_W'(1));
          rs_wdata = n_i;
        end
      end
      dco_pkg::WS_FETCH: begin
        if (cmp_lt) begin
          ns_rd_en_o = 1'b1;
          rs_re      = 1'b1;
        end else begin
          stat_o.done      = 1'b1;
          stat_o.canonical = 1'b1;
        end
      end
      dco_pkg::WS_LEFT: begin
        if (arity != '0) begin
          if (cmp_lt) begin
            rs_we    = 1'b1;
            rs_waddr = left_ix[IDX_W-1:0];
            top_d    = left_ix;
          end else if (cmp_eq) begin
            bottom_d = bottom_q + CNT_W'(1);
          end
        end
      end
      dco_pkg::WS_RIGHT: begin
        if (arity[1]) begin
          if (cmp_lt) begin
            rs_we    = 1'b1;
            rs_waddr = right_ix[IDX_W-1:0];
            top_d    = right_ix;
          end else if (cmp_eq) begin
            bottom_d = bottom_q + CNT_W'(1);
          end
        end
      end
      dco_pkg::WS_SELF: begin
        if (cmp_lt) begin
          stat_o.done = 1'b1;
        end else begin
          if (cmp_eq) bottom_d = bottom_q + CNT_W'(1);
          top_d = rs_rdata;
        end
      end
      default: ;
    endcase
  end

  assign ns_rd_addr_o = top_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dco_pkg::WS_IDLE;
      top_q    <= '0;
      bottom_q <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      bottom_q <= bottom_d;
      n_q      <= n_d;
    end
  end

  dco_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_NODES)
  ) u_ret_stack (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .re_i    (rs_re),
    .raddr_i (top_q[IDX_W-1:0]),
    .rdata_o (rs_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dco_checker.sv
// ----------------------------------------------------------------------------
// dco_checker
// port-level checks of the dag canonical order checker, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dco_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  // a stalled result item stays offered
  `DCO_ASSERT_NXT(a_out_hold, clk_i, rst_ni,
                  out_valid_i && !out_ready_i, out_valid_i,
                  "result item dropped while stalled")

  // the load is closed in the cycle after the last node of a dag is taken
  `DCO_ASSERT_NXT(a_last_closes, clk_i, rst_ni,
                  in_valid_i && in_ready_i && in_last_i, !in_ready_i,
                  "node item taken right after last node")

  // a new result only appears out of the done phase, never during loading
  `DCO_ASSERT_IMP(a_result_src, clk_i, rst_ni,
                  $rose(out_valid_i), $past(!in_ready_i),
                  "result item appeared during load phase")

endmodule

bind dag_canonical_order_checker dco_checker u_dco_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_node),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire
